// ===== hw/rtl/kovl_pkg.sv =====
// kovl_pkg: shared constants, error codes and the ranking compare for the
// k-overlap interval admission block. No dependencies.
package kovl_pkg;

	// fixed port widths
	localparam int COORD_W = 32;
	localparam int ID_W    = 20;
	localparam int LIMIT_W = 5;
	localparam int ERR_W   = 2;

	// defaults for the top level parameters
	localparam int DEF_MAX_LIMIT  = 16;
	localparam int DEF_COORD_BITS = 32;
	localparam int DEF_TAG_BITS   = 20;

	// width used when comparing live count with the limit (holds 64)
	localparam int CMP_W = 8;

	localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
	localparam logic [ERR_W-1:0] ERR_RANGE = 2'd1;
	localparam logic [ERR_W-1:0] ERR_ORDER = 2'd2;

	localparam logic [ID_W-1:0] DROP_CNT_MAX = '1;

	// larger end wins, equal ends go to the larger tag
	function automatic logic outranks(input logic [63:0] e1, input logic [63:0] t1,
			input logic [63:0] e2, input logic [63:0] t2);
		return (e1 > e2) || ((e1 == e2) && (t1 > t2));
	endfunction

endpackage

// ===== hw/rtl/kovl_rank.sv =====
// kovl_rank: expiry of active entries against a new start, and a compare tree
// that finds the top-ranked survivor, the first free slot and the live count.
// Depends on kovl_pkg.
module kovl_rank import kovl_pkg::*; #(
	parameter int MAX_LIMIT  = DEF_MAX_LIMIT,
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int TAG_BITS   = DEF_TAG_BITS,
	localparam int IDX_W = (MAX_LIMIT > 1) ? $clog2(MAX_LIMIT) : 1,
	localparam int CNT_W = $clog2(MAX_LIMIT + 1)
) (
	input  logic [COORD_BITS-1:0] start,
	input  logic [MAX_LIMIT-1:0]  vld,
	input  logic [COORD_BITS-1:0] ends [MAX_LIMIT],
	input  logic [TAG_BITS-1:0]   tags [MAX_LIMIT],
	output logic [MAX_LIMIT-1:0]  surv,
	output logic                  best_has,
	output logic [IDX_W-1:0]      best_idx,
	output logic [COORD_BITS-1:0] best_end,
	output logic [TAG_BITS-1:0]   best_tag,
	output logic                  free_has,
	output logic [IDX_W-1:0]      free_idx,
	output logic [CNT_W-1:0]      live_cnt
);

	localparam int LVL = $clog2(MAX_LIMIT);
	localparam int P   = 1 << LVL;
	localparam int N   = 2 * P - 1;

	logic                  nb_has [N];
	logic [IDX_W-1:0]      nb_idx [N];
	logic [COORD_BITS-1:0] nb_end [N];
	logic [TAG_BITS-1:0]   nb_tag [N];
	logic                  nf_has [N];
	logic [IDX_W-1:0]      nf_idx [N];
	logic [CNT_W-1:0]      n_cnt  [N];

	genvar gi;
	generate
		for (gi = 0; gi < P; gi++) begin : g_leaf
			if (gi < MAX_LIMIT) begin : g_real
				// an entry survives unless its end lies below the new start
				assign surv[gi]             = vld[gi] && !(ends[gi] < start);
				assign nb_has[P - 1 + gi]   = surv[gi];
				assign nb_idx[P - 1 + gi]   = IDX_W'(gi);
				assign nb_end[P - 1 + gi]   = ends[gi];
				assign nb_tag[P - 1 + gi]   = tags[gi];
				assign nf_has[P - 1 + gi]   = !surv[gi];
				assign nf_idx[P - 1 + gi]   = IDX_W'(gi);
				assign n_cnt[P - 1 + gi]    = CNT_W'(surv[gi]);
			end else begin : g_pad
				assign nb_has[P - 1 + gi]   = 1'b0;
				assign nb_idx[P - 1 + gi]   = '0;
				assign nb_end[P - 1 + gi]   = '0;
				assign nb_tag[P - 1 + gi]   = '0;
				assign nf_has[P - 1 + gi]   = 1'b0;
				assign nf_idx[P - 1 + gi]   = '0;
				assign n_cnt[P - 1 + gi]    = '0;
			end
		end

		for (gi = 0; gi < P - 1; gi++) begin : g_node
			logic take_r;
			// right side replaces left when left is empty or right strictly outranks it
			assign take_r = nb_has[2*gi+2] && (!nb_has[2*gi+1] ||
				outranks(64'(nb_end[2*gi+2]), 64'(nb_tag[2*gi+2]),
					64'(nb_end[2*gi+1]), 64'(nb_tag[2*gi+1])));
			assign nb_has[gi] = nb_has[2*gi+1] || nb_has[2*gi+2];
			assign nb_idx[gi] = take_r ? nb_idx[2*gi+2] : nb_idx[2*gi+1];
			assign nb_end[gi] = take_r ? nb_end[2*gi+2] : nb_end[2*gi+1];
			assign nb_tag[gi] = take_r ? nb_tag[2*gi+2] : nb_tag[2*gi+1];
			assign nf_has[gi] = nf_has[2*gi+1] || nf_has[2*gi+2];
			assign nf_idx[gi] = nf_has[2*gi+1] ? nf_idx[2*gi+1] : nf_idx[2*gi+2];
			assign n_cnt[gi]  = n_cnt[2*gi+1] + n_cnt[2*gi+2];
		end
	endgenerate

	assign best_has = nb_has[0];
	assign best_idx = nb_idx[0];
	assign best_end = nb_end[0];
	assign best_tag = nb_tag[0];
	assign free_has = nf_has[0];
	assign free_idx = nf_idx[0];
	assign live_cnt = n_cnt[0];

endmodule

// ===== hw/rtl/k_overlap_interval_admission_top.sv =====
// k_overlap_interval_admission_top: greedy k-overlap interval admission,
// one result word per input word. Depends on kovl_pkg and kovl_rank.

// Intervals arrive sorted by start; each accepted word gives exactly one result word, via the
// input and result registers; a new word is taken every cycle while out_stall is low. The
// input register feeds one pass of expiry compares and a compare tree over the MAX_LIMIT
// active slots; the slot table, previous start and drop count update at the same edge that
// loads the result register, so the next word already sees them. The limit register
// (overlap_limit, reset 1, 0 acts as 1, values above MAX_LIMIT act as MAX_LIMIT) is written
// through the cfg channel, always ready, and must only change while the block is idle.
// stream_restart clears the active set, drop count and order check before its word is used.
module k_overlap_interval_admission_top import kovl_pkg::*; #(
	parameter int MAX_LIMIT  = DEF_MAX_LIMIT,
	parameter int COORD_BITS = DEF_COORD_BITS,
	parameter int TAG_BITS   = DEF_TAG_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [LIMIT_W-1:0] overlap_limit,
	// input words
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [COORD_W-1:0] seg_start,
	input  logic [COORD_W-1:0] seg_end,
	input  logic [ID_W-1:0]    seg_id,
	input  logic               stream_restart,
	// result words
	output logic               out_valid,
	input  logic               out_stall,
	output logic               drop_valid,
	output logic [ID_W-1:0]    dropped_id,
	output logic [ID_W-1:0]    drop_total,
	output logic [ERR_W-1:0]   input_error
);

	localparam int IDX_W = (MAX_LIMIT > 1) ? $clog2(MAX_LIMIT) : 1;
	localparam int CNT_W = $clog2(MAX_LIMIT + 1);

	// input register
	logic                  valid_s1;
	logic [COORD_BITS-1:0] start_s1;
	logic [COORD_BITS-1:0] end_s1;
	logic [TAG_BITS-1:0]   tag_s1;
	logic                  restart_s1;

	// block state
	logic [COORD_BITS-1:0] act_end_q [MAX_LIMIT];
	logic [TAG_BITS-1:0]   act_tag_q [MAX_LIMIT];
	logic [MAX_LIMIT-1:0]  act_vld_q;
	logic [COORD_BITS-1:0] prev_start_q;
	logic [ID_W-1:0]       drop_cnt_q;
	logic [LIMIT_W-1:0]    lim_q;

	// result register
	logic                  out_valid_q;
	logic                  drop_valid_q;
	logic [ID_W-1:0]       dropped_id_q;
	logic [ID_W-1:0]       drop_total_q;
	logic [ERR_W-1:0]      input_error_q;

	logic                  load_s1;
	logic                  adv;
	logic [63:0]           start_x;
	logic [63:0]           end_x;
	logic [63:0]           id_x;
	logic [63:0]           drop_tag_x;

	logic [MAX_LIMIT-1:0]  vld_eff;
	logic [COORD_BITS-1:0] prev_eff;
	logic [ID_W-1:0]       cnt_eff;
	logic [ERR_W-1:0]      err;
	logic                  ok;

	logic [MAX_LIMIT-1:0]  surv;
	logic                  best_has;
	logic [IDX_W-1:0]      best_idx;
	logic [COORD_BITS-1:0] best_end;
	logic [TAG_BITS-1:0]   best_tag;
	logic                  free_has;
	logic [IDX_W-1:0]      free_idx;
	logic [CNT_W-1:0]      live_cnt;

	logic [CMP_W-1:0]      lim_eff;
	logic                  need_drop;
	logic                  new_wins;
	logic [TAG_BITS-1:0]   drop_tag;
	logic                  replace;
	logic                  insert;
	logic [ID_W-1:0]       cnt_next;
	logic [MAX_LIMIT-1:0]  vld_next;

	assign cfg_ready = 1'b1;

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;
	assign load_s1  = in_valid && !in_stall;

	assign start_x = 64'(seg_start);
	assign end_x   = 64'(seg_end);
	assign id_x    = 64'(seg_id);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			start_s1   <= start_x[COORD_BITS-1:0];
			end_s1     <= end_x[COORD_BITS-1:0];
			tag_s1     <= id_x[TAG_BITS-1:0];
			restart_s1 <= stream_restart;
		end
	end

	// restart acts on the state before the word is handled
	assign vld_eff  = restart_s1 ? '0 : act_vld_q;
	assign prev_eff = restart_s1 ? '0 : prev_start_q;
	assign cnt_eff  = restart_s1 ? '0 : drop_cnt_q;

	always_comb begin
		if (start_s1 > end_s1) begin
			err = ERR_RANGE;
		end else if (start_s1 < prev_eff) begin
			err = ERR_ORDER;
		end else begin
			err = ERR_NONE;
		end
	end
	assign ok = (err == ERR_NONE);

	kovl_rank #(
		.MAX_LIMIT  (MAX_LIMIT),
		.COORD_BITS (COORD_BITS),
		.TAG_BITS   (TAG_BITS)
	) u_rank (
		.start    (start_s1),
		.vld      (vld_eff),
		.ends     (act_end_q),
		.tags     (act_tag_q),
		.surv     (surv),
		.best_has (best_has),
		.best_idx (best_idx),
		.best_end (best_end),
		.best_tag (best_tag),
		.free_has (free_has),
		.free_idx (free_idx),
		.live_cnt (live_cnt)
	);

	always_comb begin
		if (lim_q == '0) begin
			lim_eff = CMP_W'(1);
		end else if (CMP_W'(lim_q) > CMP_W'(MAX_LIMIT)) begin
			lim_eff = CMP_W'(MAX_LIMIT);
		end else begin
			lim_eff = CMP_W'(lim_q);
		end
	end

	// count + 1 > limit, with the new interval counted in
	assign need_drop = ok && best_has && (CMP_W'(live_cnt) >= lim_eff);
	assign new_wins  = outranks(64'(end_s1), 64'(tag_s1), 64'(best_end), 64'(best_tag));
	assign drop_tag  = new_wins ? tag_s1 : best_tag;
	assign drop_tag_x = 64'(drop_tag);
	assign replace   = need_drop && !new_wins;
	assign insert    = ok && !need_drop && free_has;
	assign cnt_next  = (need_drop && (cnt_eff != DROP_CNT_MAX)) ? cnt_eff + 1'b1 : cnt_eff;

	always_comb begin
		vld_next = ok ? surv : vld_eff;
		for (int i = 0; i < MAX_LIMIT; i++) begin
			if (insert && (free_idx == IDX_W'(i))) begin
				vld_next[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_vld_q    <= '0;
			prev_start_q <= '0;
			drop_cnt_q   <= '0;
		end else if (adv) begin
			act_vld_q  <= vld_next;
			drop_cnt_q <= cnt_next;
			if (ok) begin
				prev_start_q <= start_s1;
			end else begin
				prev_start_q <= prev_eff;
			end
		end
	end

	// slot payload, written where the new interval lands
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_LIMIT; i++) begin
			if (adv && ((replace && (best_idx == IDX_W'(i))) ||
					(insert && (free_idx == IDX_W'(i))))) begin
				act_end_q[i] <= end_s1;
				act_tag_q[i] <= tag_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q <= LIMIT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			lim_q <= overlap_limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			drop_valid_q  <= need_drop;
			dropped_id_q  <= need_drop ? drop_tag_x[ID_W-1:0] : '0;
			drop_total_q  <= cnt_next;
			input_error_q <= err;
		end
	end

	assign out_valid   = out_valid_q;
	assign drop_valid  = drop_valid_q;
	assign dropped_id  = dropped_id_q;
	assign drop_total  = drop_total_q;
	assign input_error = input_error_q;

	// a rejected word never drops anything
	a_drop_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (err != ERR_NONE) |=> !drop_valid_q)
		else $error("drop reported for a rejected word");

	// drop count restarts from at most one after a restart word
	a_restart_count: assert property (@(posedge clk) disable iff (!arst_n)
		adv && restart_s1 |=> drop_total_q <= ID_W'(1))
		else $error("drop count not cleared by restart");

	// without a restart the drop count never goes down
	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !restart_s1 |=> drop_cnt_q >= $past(drop_cnt_q))
		else $error("drop count decreased");

	// an insert always finds a free slot below the limit
	a_insert_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ok && !need_drop |-> free_has)
		else $error("no free slot for an admitted interval");

endmodule
